>>> hdl/hrcw_pkg.sv
package hrcw_pkg;

  // fixed field widths
  localparam int CoordInW  = 8;
  localparam int RadiusW   = 4;
  localparam int CellW     = 10;
  localparam int DimW      = 9;
  localparam int CountW    = 4;
  localparam int SideW     = 3;
  localparam int PcW       = 2;
  localparam int CfgIndexW = 1;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_MAP_WIDTH  = 1'd0;
  localparam logic [CfgIndexW-1:0] CFG_MAP_HEIGHT = 1'd1;

  localparam logic [DimW-1:0] MAP_DIM_RESET = 9'd16;

  // ring sides in travel order
  localparam logic [SideW-1:0] SIDE_RIGHT      = 3'd0;
  localparam logic [SideW-1:0] SIDE_DOWN_RIGHT = 3'd1;
  localparam logic [SideW-1:0] SIDE_DOWN_LEFT  = 3'd2;
  localparam logic [SideW-1:0] SIDE_LEFT       = 3'd3;
  localparam logic [SideW-1:0] SIDE_UP_LEFT    = 3'd4;
  localparam logic [SideW-1:0] SIDE_UP_RIGHT   = 3'd5;

  // microcode addresses
  localparam logic [PcW-1:0] PC_IDLE   = 2'd0;
  localparam logic [PcW-1:0] PC_SEEK   = 2'd1;
  localparam logic [PcW-1:0] PC_WALK   = 2'd2;
  localparam logic [PcW-1:0] PC_CENTRE = 2'd3;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_SMALL,
    COND_SEEK_DONE,
    COND_LAST
  } cond_t;

  typedef struct packed {
    logic           accept;      // step waits for an input item
    logic           move;        // take one step on the grid
    logic           side_reg;    // step along the current side, else up-left
    logic           emit;        // send the current cell as an item
    logic           force_last;  // mark the emitted item as last
    cond_t          cond;        // jump condition
    logic [PcW-1:0] jump_pc;     // taken when the condition holds
    logic [PcW-1:0] next_pc;     // taken otherwise
  } ctrl_t;

  // control store
  function automatic ctrl_t hrcw_ucode(input logic [PcW-1:0] pc);
    ctrl_t w;
    w = '{accept: 1'b0, move: 1'b0, side_reg: 1'b0, emit: 1'b0, force_last: 1'b0,
          cond: COND_NONE, jump_pc: PC_IDLE, next_pc: PC_IDLE};
    unique case (pc)
      PC_IDLE: begin
        w.accept  = 1'b1;
        w.cond    = COND_SMALL;
        w.jump_pc = PC_CENTRE;
        w.next_pc = PC_SEEK;
      end
      PC_SEEK: begin
        w.move    = 1'b1;
        w.cond    = COND_SEEK_DONE;
        w.jump_pc = PC_WALK;
        w.next_pc = PC_SEEK;
      end
      PC_WALK: begin
        w.move     = 1'b1;
        w.side_reg = 1'b1;
        w.emit     = 1'b1;
        w.cond     = COND_LAST;
        w.jump_pc  = PC_IDLE;
        w.next_pc  = PC_WALK;
      end
      PC_CENTRE: begin
        w.emit       = 1'b1;
        w.force_last = 1'b1;
        w.next_pc    = PC_IDLE;
      end
      default: begin
        w.next_pc = PC_IDLE;
      end
    endcase
    return w;
  endfunction

  // column step for a side; odd rows are shifted right
  function automatic logic signed [1:0] hrcw_step_dx(input logic [SideW-1:0] side,
                                                     input logic odd);
    logic signed [1:0] d;
    d = 2'sd0;
    case (side)
      SIDE_RIGHT:      d = 2'sd1;
      SIDE_DOWN_RIGHT: d = odd ? 2'sd1 : 2'sd0;
      SIDE_DOWN_LEFT:  d = odd ? 2'sd0 : -2'sd1;
      SIDE_LEFT:       d = -2'sd1;
      SIDE_UP_LEFT:    d = odd ? 2'sd0 : -2'sd1;
      SIDE_UP_RIGHT:   d = odd ? 2'sd1 : 2'sd0;
      default:         d = 2'sd0;
    endcase
    return d;
  endfunction

  // row step for a side
  function automatic logic signed [1:0] hrcw_step_dy(input logic [SideW-1:0] side);
    logic signed [1:0] d;
    d = 2'sd0;
    case (side)
      SIDE_DOWN_RIGHT, SIDE_DOWN_LEFT: d = 2'sd1;
      SIDE_UP_LEFT, SIDE_UP_RIGHT:     d = -2'sd1;
      default:                         d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

>>> hdl/hrcw_if.sv
interface hrcw_in_if import hrcw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CoordInW-1:0] center_x;
  logic [CoordInW-1:0] center_y;
  logic [RadiusW-1:0]  radius;

  modport source (output valid, output center_x, output center_y, output radius,
                  input ready);
  modport sink (input valid, input center_x, input center_y, input radius,
                output ready);
endinterface

interface hrcw_out_if import hrcw_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CellW-1:0] cell_x;
  logic signed [CellW-1:0] cell_y;
  logic                    in_map;
  logic                    last_cell;

  modport source (output valid, output cell_x, output cell_y, output in_map,
                  output last_cell, input ready);
  modport sink (input valid, input cell_x, input cell_y, input in_map,
                input last_cell, output ready);
endinterface

>>> hdl/hex_ring_cell_walker.sv
// Lists the cells of one ring on an offset-coordinate hex grid (odd rows shifted
// right). Each input item gives a centre and a radius r; the block returns
// 6*(r-1) items, starting at the cell r-1 steps up-left of the centre and going
// right, down-right, down-left, left, up-left, up-right, each flagged in_map
// against map_width/map_height, the final one flagged last_cell. Radius 0 or 1
// returns the centre alone; radii above MAX_RADIUS are clamped. A small
// microcoded sequencer moves one grid step per cycle unless the result side
// stalls: it accepts an item, steps up-left to the start cell and then emits
// one ring cell per step. A new item is taken only once the previous ring
// has been fully emitted into the output register.
module hex_ring_cell_walker import hrcw_pkg::*; #(
  parameter int MAX_RADIUS  = 11,
  parameter int MAP_DIM_MAX = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  hrcw_in_if.sink              in_item,
  hrcw_out_if.source           out_item,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [DimW-1:0]      cfg_wdata
);

  localparam int LastW = $clog2(6 * MAX_RADIUS);
  localparam int DimSatW = DimW + 2;
  localparam logic [DimSatW-1:0] DIM_MAX = DimSatW'(MAP_DIM_MAX);
  localparam logic [RadiusW-1:0] RADIUS_MAX = RadiusW'(MAX_RADIUS);

  logic [DimW-1:0]         map_width_r, map_height_r;
  logic [PcW-1:0]          pc_r, pc_nxt;
  logic signed [CellW-1:0] walk_x_r, walk_x_nxt;
  logic signed [CellW-1:0] walk_y_r, walk_y_nxt;
  logic [SideW-1:0]        side_index_r, side_index_nxt;
  logic [CountW-1:0]       step_count_r, step_count_nxt;
  logic [CountW-1:0]       ring_steps_r, ring_steps_nxt;
  logic [LastW-1:0]        emit_cnt_r, emit_cnt_nxt;
  logic [LastW-1:0]        last_idx_r, last_idx_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [CellW-1:0] cell_x_r, cell_y_r;
  logic                    in_map_r, last_cell_r;

  ctrl_t                   ctrl;
  logic                    out_free, in_fire, hold, cond_hit, side_end, is_last;
  logic [RadiusW-1:0]      r_sat, rs_in;
  logic [SideW-1:0]        move_side;
  logic signed [1:0]       dx, dy;
  logic [DimSatW-1:0]      w_sat, h_sat;
  logic                    on_map;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= MAP_DIM_RESET;
      map_height_r <= MAP_DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAP_WIDTH:  map_width_r  <= cfg_wdata;
        CFG_MAP_HEIGHT: map_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control word fetch and handshake
  assign ctrl          = hrcw_ucode(pc_r);
  assign out_free      = !out_valid_r || out_item.ready;
  assign in_item.ready = ctrl.accept;
  assign in_fire       = in_item.valid && ctrl.accept;
  assign hold          = (ctrl.emit && !out_free) || (ctrl.accept && !in_item.valid);

  // radius clamp and derived counts
  assign r_sat = (in_item.radius > RADIUS_MAX) ? RADIUS_MAX : in_item.radius;
  assign rs_in = (r_sat > 4'd1) ? 4'(r_sat - 4'd1) : '0;

  // step vector for this cycle
  assign move_side = ctrl.side_reg ? side_index_r : SIDE_UP_LEFT;
  assign dx        = hrcw_step_dx(move_side, walk_y_r[0]);
  assign dy        = hrcw_step_dy(move_side);

  assign side_end = (step_count_r == 4'(ring_steps_r - 4'd1));
  assign is_last  = ctrl.force_last || (emit_cnt_r == last_idx_r);

  // jump condition
  always_comb begin
    case (ctrl.cond)
      COND_SMALL:     cond_hit = (r_sat <= 4'd1);
      COND_SEEK_DONE: cond_hit = side_end;
      COND_LAST:      cond_hit = is_last;
      default:        cond_hit = 1'b0;
    endcase
  end

  // sequencer and walk datapath
  always_comb begin
    pc_nxt         = pc_r;
    walk_x_nxt     = walk_x_r;
    walk_y_nxt     = walk_y_r;
    side_index_nxt = side_index_r;
    step_count_nxt = step_count_r;
    ring_steps_nxt = ring_steps_r;
    emit_cnt_nxt   = emit_cnt_r;
    last_idx_nxt   = last_idx_r;
    if (!hold) begin
      pc_nxt = cond_hit ? ctrl.jump_pc : ctrl.next_pc;
      if (in_fire) begin
        walk_x_nxt     = CellW'({2'b00, in_item.center_x});
        walk_y_nxt     = CellW'({2'b00, in_item.center_y});
        side_index_nxt = '0;
        step_count_nxt = '0;
        emit_cnt_nxt   = '0;
        ring_steps_nxt = rs_in;
        last_idx_nxt   = LastW'(LastW'(rs_in) * LastW'(6) - LastW'(1));
      end
      if (ctrl.move) begin
        walk_x_nxt = walk_x_r + CellW'(dx);
        walk_y_nxt = walk_y_r + CellW'(dy);
        if (side_end) begin
          step_count_nxt = '0;
          if (ctrl.side_reg) side_index_nxt = 3'(side_index_r + 3'd1);
        end else begin
          step_count_nxt = 4'(step_count_r + 4'd1);
        end
      end
      if (ctrl.emit) emit_cnt_nxt = LastW'(emit_cnt_r + LastW'(1));
    end
  end

  // in-map test against clamped map size
  assign w_sat  = ({2'b00, map_width_r} > DIM_MAX) ? DIM_MAX : {2'b00, map_width_r};
  assign h_sat  = ({2'b00, map_height_r} > DIM_MAX) ? DIM_MAX : {2'b00, map_height_r};
  assign on_map = !walk_x_r[CellW-1] && !walk_y_r[CellW-1] &&
                  ({2'b00, walk_x_r[CellW-2:0]} < w_sat) &&
                  ({2'b00, walk_y_r[CellW-2:0]} < h_sat);

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.emit && out_free) out_valid_nxt = 1'b1;
    else if (out_item.ready)   out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= PC_IDLE;
      out_valid_r  <= 1'b0;
      walk_x_r     <= '0;
      walk_y_r     <= '0;
      side_index_r <= '0;
      step_count_r <= '0;
      ring_steps_r <= '0;
      emit_cnt_r   <= '0;
      last_idx_r   <= '0;
    end else begin
      pc_r         <= pc_nxt;
      out_valid_r  <= out_valid_nxt;
      walk_x_r     <= walk_x_nxt;
      walk_y_r     <= walk_y_nxt;
      side_index_r <= side_index_nxt;
      step_count_r <= step_count_nxt;
      ring_steps_r <= ring_steps_nxt;
      emit_cnt_r   <= emit_cnt_nxt;
      last_idx_r   <= last_idx_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ctrl.emit && out_free) begin
      cell_x_r    <= walk_x_r;
      cell_y_r    <= walk_y_r;
      in_map_r    <= on_map;
      last_cell_r <= is_last;
    end
  end

  assign out_item.valid     = out_valid_r;
  assign out_item.cell_x    = cell_x_r;
  assign out_item.cell_y    = cell_y_r;
  assign out_item.in_map    = in_map_r;
  assign out_item.last_cell = last_cell_r;

endmodule

>>> hdl/hrcw_checker.sv
module hrcw_checker import hrcw_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [CellW-1:0] cell_x,
  input logic signed [CellW-1:0] cell_y,
  input logic                    in_map,
  input logic                    last_cell
);

  // a stalled item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // an accepted item starts a walk, so input closes next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after accepting an item");

  // ring not finished while a non-final cell is pending
  a_busy_mid_ring: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last_cell |-> !in_ready)
    else $error("input open before ring finished");

  // in-map cells never have negative coordinates
  a_in_map_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && in_map |-> !cell_x[CellW-1] && !cell_y[CellW-1])
    else $error("negative cell flagged in map");

endmodule

bind hex_ring_cell_walker hrcw_checker u_hrcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_item.valid),
  .in_ready  (in_item.ready),
  .out_valid (out_item.valid),
  .out_ready (out_item.ready),
  .cell_x    (out_item.cell_x),
  .cell_y    (out_item.cell_y),
  .in_map    (out_item.in_map),
  .last_cell (out_item.last_cell)
);

>>> tb/hrcw_ring_checker.sv
module hrcw_ring_checker import hrcw_pkg::*; #(
  parameter int MAX_RADIUS  = 11,
  parameter int MAP_DIM_MAX = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  hrcw_in_if                   in_mon,
  hrcw_out_if                  out_mon,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [DimW-1:0]      cfg_wdata,
  output int                   fail_count,
  output int                   cells_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [CellW-1:0] x;
    logic signed [CellW-1:0] y;
    logic                    in_map;
    logic                    last_cell;
  } ring_cell_t;

  ring_cell_t      ring_cells_q[$];
  logic [DimW-1:0] map_w;
  logic [DimW-1:0] map_h;
  int              fails;

  // one grid step along a side, vector picked by row parity
  function automatic void hex_step(input logic [SideW-1:0] side, inout int px, inout int py);
    logic odd;
    odd = py[0];
    case (side)
      SIDE_RIGHT: px = px + 1;
      SIDE_DOWN_RIGHT: begin
        px = px + (odd ? 1 : 0);
        py = py + 1;
      end
      SIDE_DOWN_LEFT: begin
        px = px - (odd ? 0 : 1);
        py = py + 1;
      end
      SIDE_LEFT: px = px - 1;
      SIDE_UP_LEFT: begin
        px = px - (odd ? 0 : 1);
        py = py - 1;
      end
      SIDE_UP_RIGHT: begin
        px = px + (odd ? 1 : 0);
        py = py - 1;
      end
      default: ;
    endcase
  endfunction

  // bounds test against the map size, saturated to the largest map
  function automatic void queue_cell(input int px, input int py, input logic last);
    ring_cell_t c;
    int         w;
    int         h;
    w = (int'(map_w) > MAP_DIM_MAX) ? MAP_DIM_MAX : int'(map_w);
    h = (int'(map_h) > MAP_DIM_MAX) ? MAP_DIM_MAX : int'(map_h);
    c.x         = px[CellW-1:0];
    c.y         = py[CellW-1:0];
    c.in_map    = (px >= 0) && (py >= 0) && (px < w) && (py < h);
    c.last_cell = last;
    ring_cells_q.push_back(c);
  endfunction

  // all cells of one ring, in emission order
  function automatic void trace_ring(input logic [CoordInW-1:0] cx,
                                     input logic [CoordInW-1:0] cy,
                                     input logic [RadiusW-1:0]  rad);
    int px;
    int py;
    int steps;
    int total;
    px = int'(cx);
    py = int'(cy);
    steps = ((int'(rad) > MAX_RADIUS) ? MAX_RADIUS : int'(rad)) - 1;
    if (steps <= 0) begin
      queue_cell(px, py, 1'b1);
    end else begin
      total = 6 * steps;
      for (int i = 0; i < steps; i++) hex_step(SIDE_UP_LEFT, px, py);
      queue_cell(px, py, 1'b0);
      // the step back onto the start cell is never taken
      for (int k = 1; k < total; k++) begin
        hex_step(SideW'((k - 1) / steps), px, py);
        queue_cell(px, py, k == total - 1);
      end
    end
  endfunction

  always @(posedge clk) begin
    ring_cell_t want;
    ring_cell_t got;
    if (!rst_n) begin
      ring_cells_q.delete();
      map_w = MAP_DIM_RESET;
      map_h = MAP_DIM_RESET;
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_index == CFG_MAP_WIDTH) map_w = cfg_wdata;
        else if (cfg_index == CFG_MAP_HEIGHT) map_h = cfg_wdata;
      end
      // accepted ring requests
      if (in_mon.valid && in_mon.ready)
        trace_ring(in_mon.center_x, in_mon.center_y, in_mon.radius);
      // accepted cells against the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        got = '{x: out_mon.cell_x, y: out_mon.cell_y, in_map: out_mon.in_map,
                last_cell: out_mon.last_cell};
        if (ring_cells_q.size() == 0) begin
          fails++;
          $display("%0t: expected none, got x=%0d y=%0d in_map=%0b last=%0b",
                   $time, got.x, got.y, got.in_map, got.last_cell);
        end else begin
          want = ring_cells_q[0];
          ring_cells_q.delete(0);
          if (got !== want) begin
            fails++;
            $display("%0t: expected x=%0d y=%0d in_map=%0b last=%0b",
                     $time, want.x, want.y, want.in_map, want.last_cell);
            $display("%0t: got x=%0d y=%0d in_map=%0b last=%0b",
                     $time, got.x, got.y, got.in_map, got.last_cell);
          end
        end
      end
    end
    fail_count <= fails;
    cells_due  <= ring_cells_q.size();
  end

endmodule

>>> tb/hex_ring_cell_walker_tb.sv
module hex_ring_cell_walker_tb;
  import hrcw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 80;
  localparam int ITEMS_PER_PHASE = 45;
  localparam int PHASES          = 8;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [DimW-1:0]      cfg_wdata;
  int                   fail_count;
  int                   cells_due;
  bit                   no_idle;
  int                   phase_w[6] = '{1, 256, 0, 16, 511, 257};
  int                   phase_h[6] = '{1, 256, 16, 0, 511, 3};

  hrcw_in_if  in_if();
  hrcw_out_if out_if();

  hex_ring_cell_walker u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_if),
    .out_item (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  hrcw_ring_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .cells_due (cells_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // one ring request, after a random gap
  task automatic push_ring(input logic [CoordInW-1:0] x, input logic [CoordInW-1:0] y,
                           input logic [RadiusW-1:0] r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.center_x <= x;
    in_if.center_y <= y;
    in_if.radius   <= r;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // stop sending and wait for every outstanding cell
  task automatic drain_rings();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (cells_due != 0) @(posedge clk);
  endtask

  task automatic set_map(input int w, input int h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAP_WIDTH;
    cfg_wdata <= DimW'(w);
    @(posedge clk);
    cfg_index <= CFG_MAP_HEIGHT;
    cfg_wdata <= DimW'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side stalls
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  // watchdog on cycles with no handshake and no register write
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int w;
    int h;
    int lim_x;
    int lim_y;
    int pick;
    logic [CoordInW-1:0] x;
    logic [CoordInW-1:0] y;
    logic [RadiusW-1:0]  r;

    no_idle        = 1'b0;
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.center_x <= '0;
    in_if.center_y <= '0;
    in_if.radius   <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_MAP_WIDTH;
    cfg_wdata      <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rings on the 16x16 reset map
    push_ring(8'd0, 8'd0, 4'd0);
    push_ring(8'd0, 8'd0, 4'd1);
    push_ring(8'd255, 8'd255, 4'd1);
    push_ring(8'd7, 8'd7, 4'd2);
    push_ring(8'd6, 8'd6, 4'd2);
    push_ring(8'd8, 8'd3, 4'd3);
    push_ring(8'd8, 8'd4, 4'd3);
    push_ring(8'd0, 8'd0, 4'd11);
    push_ring(8'd255, 8'd255, 4'd11);
    push_ring(8'd255, 8'd0, 4'd15);
    push_ring(8'd0, 8'd255, 4'd12);
    push_ring(8'd128, 8'd128, 4'd11);
    push_ring(8'd15, 8'd15, 4'd5);
    push_ring(8'd0, 8'd15, 4'd4);
    push_ring(8'd15, 8'd0, 4'd4);
    push_ring(8'd170, 8'd85, 4'd10);
    push_ring(8'd85, 8'd170, 4'd7);
    push_ring(8'd3, 8'd1, 4'd14);
    push_ring(8'd12, 8'd9, 4'd6);
    drain_rings();

    // random rings under a series of map sizes
    for (int phase = 0; phase < PHASES; phase++) begin
      repeat (2) @(posedge clk);
      if (phase < 6) begin
        w = phase_w[phase];
        h = phase_h[phase];
      end else begin
        w = $urandom_range(0, 511);
        h = $urandom_range(0, 511);
      end
      set_map(w, h);
      lim_x = (w > 252) ? 255 : w + 3;
      lim_y = (h > 252) ? 255 : h + 3;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 15 == 0) no_idle = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 19);
        if (pick < 2) r = RadiusW'($urandom_range(0, 1));
        else if (pick == 2) r = RadiusW'($urandom_range(12, 15));
        else r = RadiusW'($urandom_range(2, 11));
        // centres mostly near the map so rings straddle its edges
        if ($urandom_range(0, 2) != 0) begin
          x = CoordInW'($urandom_range(0, lim_x));
          y = CoordInW'($urandom_range(0, lim_y));
        end else begin
          x = CoordInW'($urandom_range(0, 255));
          y = CoordInW'($urandom_range(0, 255));
        end
        push_ring(x, y, r);
      end
      no_idle = 1'b0;
      drain_rings();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> files.f
hdl/hrcw_pkg.sv
hdl/hrcw_if.sv
hdl/hex_ring_cell_walker.sv
hdl/hrcw_checker.sv
tb/hrcw_ring_checker.sv
tb/hex_ring_cell_walker_tb.sv
